// ===== src/psqt_pkg.sv =====
package psqt_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FIELD_W  = 32;
  localparam int REC_W    = 3 * FIELD_W;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic add;
    logic start;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic             empty;
    logic             full;
    logic             last;
    logic             out_busy;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

// ===== src/psqt_ram.sv =====
module psqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/psqt_ctrl.sv =====
module psqt_ctrl
  import psqt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_mode,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_ADD) begin
            cmd.add = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = sts.empty ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/psqt_dp.sv =====
module psqt_dp
  import psqt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [REC_W-1:0]   in_rec,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [REC_W-1:0]   out_rec
);

  logic [CNT_W-1:0]          count;
  logic [ADDR_W-1:0]         ptr;
  logic signed [FIELD_W-1:0] limit;
  logic                      have;
  logic                      cmp_valid;
  logic signed [FIELD_W-1:0] best_score;
  logic signed [FIELD_W-1:0] best_id;
  logic [FIELD_W-1:0]        best_tag;
  logic [REC_W-1:0]          rd_rec;
  logic signed [FIELD_W-1:0] rd_score;
  logic signed [FIELD_W-1:0] rd_id;
  logic [FIELD_W-1:0]        rd_tag;
  logic                      full;
  logic                      wr_en;
  logic                      take;

  // record layout: score low, id, name tag high
  psqt_ram #(
    .WIDTH(REC_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[ADDR_W-1:0]),
    .wdata(in_rec),
    .raddr(ptr),
    .rdata(rd_rec)
  );

  assign full     = (count == CNT_W'(CAPACITY));
  assign wr_en    = cmd.add && !full;
  assign rd_score = rd_rec[FIELD_W-1:0];
  assign rd_id    = rd_rec[2*FIELD_W-1:FIELD_W];
  assign rd_tag   = rd_rec[3*FIELD_W-1:2*FIELD_W];

  assign take = cmp_valid && (rd_score < limit) &&
                (!have || (rd_score > best_score) ||
                 ((rd_score == best_score) && (rd_id >= best_id)));

  assign sts.empty    = (count == '0);
  assign sts.full     = full;
  assign sts.last     = ({1'b0, ptr} == count - CNT_W'(1));
  assign sts.out_busy = out_valid && !out_ready;
  assign sts.count    = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      have      <= 1'b0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.start) begin
        ptr  <= '0;
        have <= 1'b0;
      end else if (cmd.step) begin
        ptr <= ptr + ADDR_W'(1);
      end
      if (take) begin
        have <= 1'b1;
      end
      cmp_valid <= cmd.step;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      limit <= in_rec[FIELD_W-1:0];
    end
    if (take) begin
      best_score <= rd_score;
      best_id    <= rd_id;
      best_tag   <= rd_tag;
    end
    if (cmd.load) begin
      out_found <= have;
      out_rec   <= have ? {best_score, best_id, best_tag} : '0;
    end
  end

endmodule

// ===== src/predecessor_score_query_table_top.sv =====
// Record table with predecessor lookup. An add item (tuser = 0) stores a
// score, id and name tag and gives no result; adds beyond 1024 records are
// dropped. A query item (tuser = 1) walks the stored records through one
// read port of the record memory, one record per cycle, and returns the
// record with the largest score strictly below the query score, ties going
// to the largest id and then to the latest add. A query holds the block
// until its done state, waiting there while an earlier result is untaken;
// the result sits in an output register so the next item is taken while it
// waits. found = 0 means nobody, with all other result fields zero.
module predecessor_score_query_table_top
  import psqt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [REC_W-1:0] s_axis_tdata,  // score, student_id, name_tag
  input  logic             s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [REC_W-1:0] m_axis_tdata,  // best_name_tag, best_id, best_score
  output logic             m_axis_tuser   // found
);

  cmd_t cmd;
  sts_t sts;

  psqt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_mode (s_axis_tuser),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  psqt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_rec   (s_axis_tdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_found(m_axis_tuser),
    .out_rec  (m_axis_tdata)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    sts.count <= CNT_W'(CAPACITY))
    else $error("record count beyond capacity");

  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_ADD) && !sts.full)
    |=> (sts.count == $past(sts.count) + CNT_W'(1)))
    else $error("add not counted");

  a_nobody_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("nobody result carries data");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_QUERY))
    |=> !s_axis_tready)
    else $error("item taken during query");

endmodule
